>>> hw/rtl/mcfe_pkg.sv
`default_nettype none
package mcfe_pkg;

   // width of one Q16.16 value
   localparam int VALUE_W   = 32;
   // dividend width: offset times the largest code span
   localparam int DIVIDEND_W = 48;
   // one quotient bit per divider stage, enough for the widest code
   localparam int DIV_STEPS = 16;

   // code widths of the five frame fields
   localparam int KP_BITS  = 12;
   localparam int KD_BITS  = 9;
   localparam int POS_BITS = 16;
   localparam int SPD_BITS = 12;
   localparam int TOR_BITS = 12;

   // first identifier that goes to the second bus
   localparam logic [10:0] BUS1_FIRST_IDENT = 11'd7;
   localparam logic [3:0]  FRAME_BYTES      = 4'd8;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_HIGH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_LOW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_HIGH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TORQUE_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TORQUE_HIGH = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_P_HIGH = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_D_HIGH = 3'd7;

   typedef struct packed {
      logic [10:0]        motor_ident;
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_d;
      logic signed [31:0] target_pos;
      logic signed [31:0] target_speed;
      logic signed [31:0] target_torque;
   } req_type;

   typedef struct packed {
      logic [10:0] frame_ident;
      logic        bus_select;
      logic [31:0] payload_low;
      logic [31:0] payload_high;
      logic [3:0]  frame_length;
      logic        bad_range;
   } rsp_type;

endpackage
`default_nettype wire

>>> hw/rtl/mcfe_scale_lane.sv
`default_nettype none
// Clamp one value to [lo, hi] and scale it to a code of CODE_BITS bits:
// code = floor((x - lo) * (2^CODE_BITS - 1) / (hi - lo)), restoring division
// with one quotient bit per active stage; stages for quotient bits above the code width only pass data on. No stall.
module mcfe_scale_lane #(
   parameter int CODE_BITS = 12
) (
   input  wire logic                                   clock,
   input  wire logic signed [mcfe_pkg::VALUE_W-1:0]    x,
   input  wire logic signed [mcfe_pkg::VALUE_W-1:0]    lo,
   input  wire logic signed [mcfe_pkg::VALUE_W-1:0]    hi,
   output logic [CODE_BITS-1:0]                        code,
   output logic                                        bad
);

   localparam int VW    = mcfe_pkg::VALUE_W;
   localparam int DW    = mcfe_pkg::DIVIDEND_W;
   localparam int STEPS = mcfe_pkg::DIV_STEPS;

   // stage A: clamp and range check
   logic signed [VW-1:0] xc_ff, xc_in;
   logic signed [VW-1:0] lo_ff, hi_ff;
   logic                 bada_ff, bada_in;

   always_comb begin
      bada_in = (hi <= lo);
      if (x > hi) begin
         xc_in = hi;
      end else if (x < lo) begin
         xc_in = lo;
      end else begin
         xc_in = x;
      end
   end

   always_ff @(posedge clock) begin
      xc_ff   <= xc_in;
      lo_ff   <= lo;
      hi_ff   <= hi;
      bada_ff <= bada_in;
   end

   // stage B: offset, span and dividend
   logic signed [VW:0] offs_wide, span_wide;
   logic [DW-1:0]      offs_ext;
   logic [DW-1:0]      rem_ff   [STEPS+1];
   logic [VW-1:0]      span_ff  [STEPS+1];
   logic [CODE_BITS-1:0] quo_ff [STEPS+1];
   logic               bad_ff   [STEPS+1];

   always_comb begin
      offs_wide = {xc_ff[VW-1], xc_ff} - {lo_ff[VW-1], lo_ff};
      span_wide = {hi_ff[VW-1], hi_ff} - {lo_ff[VW-1], lo_ff};
      offs_ext  = DW'(offs_wide[VW-1:0]);
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= (offs_ext << CODE_BITS) - offs_ext;
      span_ff[0] <= span_wide[VW-1:0];
      quo_ff[0]  <= '0;
      bad_ff[0]  <= bada_ff;
   end

   // divider stages, most significant quotient bit first
   for (genvar k = 0; k < STEPS; k++) begin : g_div
      localparam int QBIT = STEPS - 1 - k;
      if (QBIT < CODE_BITS) begin : g_act
         logic [DW-1:0] trial;
         logic          take;
         always_comb begin
            trial = DW'(span_ff[k]) << QBIT;
            take  = (rem_ff[k] >= trial);
         end
         always_ff @(posedge clock) begin
            rem_ff[k+1]  <= take ? (rem_ff[k] - trial) : rem_ff[k];
            quo_ff[k+1]  <= quo_ff[k] | (take ? (CODE_BITS'(1) << QBIT) : '0);
            span_ff[k+1] <= span_ff[k];
            bad_ff[k+1]  <= bad_ff[k];
         end
      end else begin : g_pass
         always_ff @(posedge clock) begin
            rem_ff[k+1]  <= rem_ff[k];
            quo_ff[k+1]  <= quo_ff[k];
            span_ff[k+1] <= span_ff[k];
            bad_ff[k+1]  <= bad_ff[k];
         end
      end
   end

   assign code = bad_ff[STEPS] ? '0 : quo_ff[STEPS];
   assign bad  = bad_ff[STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/motor_command_frame_encoder.sv
`default_nettype none
// Motor command frame encoder. One command is taken every cycle (busy is
// always low) and its 8-byte frame appears on rsp_data with rsp_valid high
// for one cycle once the command has passed the clamp and offset stages,
// the 16-stage restoring divider and the output register. The receiver
// cannot hold a result off. Range registers may only be written while no
// command is in flight.
module motor_command_frame_encoder (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire mcfe_pkg::req_type                      req_data,
   output logic                                        rsp_valid,
   output mcfe_pkg::rsp_type                           rsp_data,
   input  wire logic                                   csr_we,
   input  wire logic [mcfe_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [31:0]                            csr_wdata
);

   localparam int LANE_LAT = mcfe_pkg::DIV_STEPS + 2;

   // configuration registers
   logic signed [31:0] pos_low_ff, pos_high_ff, speed_low_ff, speed_high_ff;
   logic signed [31:0] torque_low_ff, torque_high_ff;
   logic [30:0]        gain_p_high_ff, gain_d_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_low_ff     <= -32'sd819200;
         pos_high_ff    <= 32'sd819200;
         speed_low_ff   <= -32'sd4259840;
         speed_high_ff  <= 32'sd4259840;
         torque_low_ff  <= -32'sd1179648;
         torque_high_ff <= 32'sd1179648;
         gain_p_high_ff <= 31'd32768000;
         gain_d_high_ff <= 31'd327680;
      end else if (csr_we) begin
         case (csr_index)
            mcfe_pkg::REG_POS_LOW:     pos_low_ff     <= csr_wdata;
            mcfe_pkg::REG_POS_HIGH:    pos_high_ff    <= csr_wdata;
            mcfe_pkg::REG_SPEED_LOW:   speed_low_ff   <= csr_wdata;
            mcfe_pkg::REG_SPEED_HIGH:  speed_high_ff  <= csr_wdata;
            mcfe_pkg::REG_TORQUE_LOW:  torque_low_ff  <= csr_wdata;
            mcfe_pkg::REG_TORQUE_HIGH: torque_high_ff <= csr_wdata;
            mcfe_pkg::REG_GAIN_P_HIGH: gain_p_high_ff <= csr_wdata[30:0];
            mcfe_pkg::REG_GAIN_D_HIGH: gain_d_high_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // scaling lanes
   logic [mcfe_pkg::KP_BITS-1:0]  kp_code;
   logic [mcfe_pkg::KD_BITS-1:0]  kd_code;
   logic [mcfe_pkg::POS_BITS-1:0] pos_code;
   logic [mcfe_pkg::SPD_BITS-1:0] spd_code;
   logic [mcfe_pkg::TOR_BITS-1:0] tor_code;
   logic [4:0]                    lane_bad;

   mcfe_scale_lane #(.CODE_BITS(mcfe_pkg::KP_BITS)) u_kp (
      .clock(clock), .x(req_data.gain_p), .lo('0),
      .hi({1'b0, gain_p_high_ff}), .code(kp_code), .bad(lane_bad[0]));
   mcfe_scale_lane #(.CODE_BITS(mcfe_pkg::KD_BITS)) u_kd (
      .clock(clock), .x(req_data.gain_d), .lo('0),
      .hi({1'b0, gain_d_high_ff}), .code(kd_code), .bad(lane_bad[1]));
   mcfe_scale_lane #(.CODE_BITS(mcfe_pkg::POS_BITS)) u_pos (
      .clock(clock), .x(req_data.target_pos), .lo(pos_low_ff),
      .hi(pos_high_ff), .code(pos_code), .bad(lane_bad[2]));
   mcfe_scale_lane #(.CODE_BITS(mcfe_pkg::SPD_BITS)) u_spd (
      .clock(clock), .x(req_data.target_speed), .lo(speed_low_ff),
      .hi(speed_high_ff), .code(spd_code), .bad(lane_bad[3]));
   mcfe_scale_lane #(.CODE_BITS(mcfe_pkg::TOR_BITS)) u_tor (
      .clock(clock), .x(req_data.target_torque), .lo(torque_low_ff),
      .hi(torque_high_ff), .code(tor_code), .bad(lane_bad[4]));

   // valid bits and identifier travel alongside the lanes
   logic [LANE_LAT-1:0] vld_ff;
   logic [10:0]         ident_ff [LANE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LANE_LAT-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      ident_ff[0] <= req_data.motor_ident;
      for (int i = 1; i < LANE_LAT; i++) begin
         ident_ff[i] <= ident_ff[i-1];
      end
   end

   // frame packing into the output register
   logic [7:0]        byte_c [8];
   mcfe_pkg::rsp_type rsp_in, rsp_ff;
   logic              rsp_valid_ff;

   always_comb begin
      byte_c[0] = {3'b000, kp_code[11:7]};
      byte_c[1] = {kp_code[6:0], kd_code[8]};
      byte_c[2] = kd_code[7:0];
      byte_c[3] = pos_code[15:8];
      byte_c[4] = pos_code[7:0];
      byte_c[5] = spd_code[11:4];
      byte_c[6] = {spd_code[3:0], tor_code[11:8]};
      byte_c[7] = tor_code[7:0];
      rsp_in.frame_ident  = ident_ff[LANE_LAT-1];
      rsp_in.bus_select   = (ident_ff[LANE_LAT-1] >= mcfe_pkg::BUS1_FIRST_IDENT);
      rsp_in.payload_low  = {byte_c[3], byte_c[2], byte_c[1], byte_c[0]};
      rsp_in.payload_high = {byte_c[7], byte_c[6], byte_c[5], byte_c[4]};
      rsp_in.frame_length = mcfe_pkg::FRAME_BYTES;
      rsp_in.bad_range    = |lane_bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[LANE_LAT-1];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_bus_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bus_select |-> rsp_data.frame_ident < mcfe_pkg::BUS1_FIRST_IDENT)
      else $error("bus select disagrees with identifier");
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.frame_length == mcfe_pkg::FRAME_BYTES)
      else $error("frame length not eight");
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld_ff[LANE_LAT-1]))
      else $error("result without a command in flight");

endmodule
`default_nettype wire
